>>> src/itoa_pkg.sv
// Shared types, constants and helpers for the integer to ASCII radix converter.
// Used by every module of the block but itoa_ram; depends on nothing.
package itoa_pkg;

    // Field and register widths
    localparam int VALUE_W   = 32;
    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 8;
    localparam int PADCNT_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Digit store geometry
    localparam int MAX_DIGITS = 32;
    localparam int DIGIT_AW   = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_W    = RADIX_W;

    // Divider step counter
    localparam int DIV_STEP_W = $clog2(VALUE_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_COUNT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [RADIX_W-1:0]  RADIX_RST     = 6'd10;
    localparam logic [CHAR_W-1:0]   PAD_CHAR_RST  = 8'h30;
    localparam logic [PADCNT_W-1:0] PAD_COUNT_RST = 5'd0;

    // Radix limits; a sign is only shown in decimal
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;

    // Characters
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LETTER_OFS = CH_LOWER_A - CH_NINE - 8'd1;

    // One classified number waiting for conversion
    typedef struct packed {
        logic [VALUE_W-1:0] magnitude;
        logic               neg;
        logic [RADIX_W-1:0] radix;
        logic [CHAR_W-1:0]  pad_char;
        logic [CNT_W-1:0]   target;
    } t_job;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [RADIX_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } t_div_rsp;

    // Back end status
    typedef struct packed {
        logic busy;
        logic dividing;
    } t_back_sts;

    // Digit value to ASCII: 0..9 then lower-case letters
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        ch = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (ch > CH_NINE) begin
            ch = ch + CH_LETTER_OFS;
        end
        return ch;
    endfunction

endpackage

>>> src/itoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/itoa_front.sv
// Front end: configuration registers, input acceptance, classification and a
// two-entry job queue towards the back end. Depends on itoa_pkg.
module itoa_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [itoa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [itoa_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    input  logic [itoa_pkg::VALUE_W-1:0]        i_value,
    input  logic                                i_is_signed,
    output logic                                o_stall,
    output logic                                o_job_valid,
    output itoa_pkg::t_job                      o_job,
    input  logic                                i_job_take
);

    logic [itoa_pkg::RADIX_W-1:0]  r_radix;
    logic [itoa_pkg::CHAR_W-1:0]   r_pad_char;
    logic [itoa_pkg::PADCNT_W-1:0] r_pad_count;

    itoa_pkg::t_job r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_count;

    logic [itoa_pkg::RADIX_W-1:0] radix_sat;
    logic [itoa_pkg::CNT_W-1:0]   target;
    itoa_pkg::t_job               job_in;
    logic                         push;
    logic                         pop;

    // Saturate radix, clamp padding target, decide on sign
    always_comb begin
        if (r_radix < itoa_pkg::RADIX_MIN) begin
            radix_sat = itoa_pkg::RADIX_MIN;
        end else if (r_radix > itoa_pkg::RADIX_MAX) begin
            radix_sat = itoa_pkg::RADIX_MAX;
        end else begin
            radix_sat = r_radix;
        end

        if (itoa_pkg::CNT_W'(r_pad_count) > itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS - 1)) begin
            target = itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS - 1);
        end else begin
            target = itoa_pkg::CNT_W'(r_pad_count);
        end

        job_in.neg       = i_is_signed && i_value[itoa_pkg::VALUE_W-1]
                           && (radix_sat == itoa_pkg::RADIX_DECIMAL);
        job_in.magnitude = job_in.neg ? (~i_value + itoa_pkg::VALUE_W'(1)) : i_value;
        job_in.radix     = radix_sat;
        job_in.pad_char  = r_pad_char;
        job_in.target    = target;
    end

    // Queue handshake
    assign o_stall     = (r_count == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_job_valid = (r_count != 2'd0);
    assign pop         = i_job_take && o_job_valid;
    assign o_job       = r_q[r_rp];

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= itoa_pkg::RADIX_RST;
            r_pad_char  <= itoa_pkg::PAD_CHAR_RST;
            r_pad_count <= itoa_pkg::PAD_COUNT_RST;
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_count     <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    itoa_pkg::CFG_RADIX: begin
                        r_radix <= i_cfg_data[itoa_pkg::RADIX_W-1:0];
                    end
                    itoa_pkg::CFG_PAD_CHAR: begin
                        r_pad_char <= i_cfg_data[itoa_pkg::CHAR_W-1:0];
                    end
                    itoa_pkg::CFG_PAD_COUNT: begin
                        r_pad_count <= i_cfg_data[itoa_pkg::PADCNT_W-1:0];
                    end
                    default: begin
                        // unused index: ignored
                    end
                endcase
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
    end

endmodule

>>> src/itoa_div.sv
// Iterative restoring divider, one quotient bit per cycle, for a 32-bit
// dividend by a small radix. Depends on itoa_pkg.
module itoa_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itoa_pkg::t_div_req   i_req,
    output itoa_pkg::t_div_rsp   o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [itoa_pkg::DIV_STEP_W-1:0]   r_step;
    logic [itoa_pkg::VALUE_W-1:0]      r_q;
    logic [itoa_pkg::DIGIT_W-1:0]      r_rem;
    logic [itoa_pkg::RADIX_W-1:0]      r_div;

    logic [itoa_pkg::DIGIT_W:0]        sh;
    logic                              ge;
    logic [itoa_pkg::DIGIT_W-1:0]      rem_nx;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        sh     = {r_rem, r_q[itoa_pkg::VALUE_W-1]};
        ge     = (sh >= {1'b0, r_div});
        rem_nx = ge ? itoa_pkg::DIGIT_W'(sh - {1'b0, r_div}) : sh[itoa_pkg::DIGIT_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '1;
            end else if (r_busy) begin
                r_step <= r_step - itoa_pkg::DIV_STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[itoa_pkg::VALUE_W-2:0], ge};
            r_rem <= rem_nx;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule

>>> src/itoa_back.sv
// Back end: takes jobs from the queue, drives the divider, stores digits and
// emits the text one character per item through an output register.
// Depends on itoa_pkg.
module itoa_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    input  itoa_pkg::t_job                    i_job,
    output logic                              o_job_take,
    output itoa_pkg::t_div_req                o_div_req,
    input  itoa_pkg::t_div_rsp                i_div_rsp,
    output logic                              o_ram_we,
    output logic [itoa_pkg::DIGIT_AW-1:0]     o_ram_waddr,
    output logic [itoa_pkg::DIGIT_W-1:0]      o_ram_wdata,
    output logic [itoa_pkg::DIGIT_AW-1:0]     o_ram_raddr,
    input  logic [itoa_pkg::DIGIT_W-1:0]      i_ram_rdata,
    output itoa_pkg::t_back_sts               o_sts,
    output logic                              o_valid,
    output logic [itoa_pkg::CHAR_W-1:0]       o_text_char,
    output logic                              o_last,
    input  logic                              i_stall
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SIGN,
        ST_PAD,
        ST_DIG_RD,
        ST_DIG_OUT
    } t_state;

    t_state                          r_state,  n_state;
    logic [itoa_pkg::VALUE_W-1:0]    r_work,   n_work;
    logic                            r_neg,    n_neg;
    logic [itoa_pkg::RADIX_W-1:0]    r_radix,  n_radix;
    logic [itoa_pkg::CHAR_W-1:0]     r_pchar,  n_pchar;
    logic [itoa_pkg::CNT_W-1:0]      r_tgt,    n_tgt;
    logic [itoa_pkg::CNT_W-1:0]      r_cnt,    n_cnt;
    logic [itoa_pkg::CNT_W-1:0]      r_pads,   n_pads;
    logic [itoa_pkg::DIGIT_AW-1:0]   r_idx,    n_idx;
    logic                            r_o_valid, n_o_valid;
    logic [itoa_pkg::CHAR_W-1:0]     r_o_char,  n_o_char;
    logic                            r_o_last,  n_o_last;

    logic                            out_free;
    logic [itoa_pkg::CNT_W-1:0]      cnt_nx;
    logic [itoa_pkg::CNT_W-1:0]      pads_nx;

    assign out_free = !r_o_valid || !i_stall;
    assign cnt_nx   = r_cnt + itoa_pkg::CNT_W'(1);
    assign pads_nx  = (r_tgt > cnt_nx) ? (r_tgt - cnt_nx) : '0;

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_work    = r_work;
        n_neg     = r_neg;
        n_radix   = r_radix;
        n_pchar   = r_pchar;
        n_tgt     = r_tgt;
        n_cnt     = r_cnt;
        n_pads    = r_pads;
        n_idx     = r_idx;
        n_o_valid = r_o_valid && i_stall;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        o_job_take = 1'b0;
        o_ram_we   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_take = 1'b1;
                    n_work     = i_job.magnitude;
                    n_neg      = i_job.neg;
                    n_radix    = i_job.radix;
                    n_pchar    = i_job.pad_char;
                    n_tgt      = i_job.target;
                    n_cnt      = '0;
                    n_state    = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_div_rsp.done) begin
                    o_ram_we = 1'b1;
                    n_cnt    = cnt_nx;
                    n_work   = i_div_rsp.quotient;
                    if ((i_div_rsp.quotient == '0)
                        || (cnt_nx == itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS))) begin
                        n_idx  = r_cnt[itoa_pkg::DIGIT_AW-1:0];
                        n_pads = pads_nx;
                        if (r_neg) begin
                            n_state = ST_SIGN;
                        end else if (pads_nx != '0) begin
                            n_state = ST_PAD;
                        end else begin
                            n_state = ST_DIG_RD;
                        end
                    end else begin
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = itoa_pkg::CH_MINUS;
                    n_o_last  = 1'b0;
                    n_state   = (r_pads != '0) ? ST_PAD : ST_DIG_RD;
                end
            end
            ST_PAD: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = r_pchar;
                    n_o_last  = 1'b0;
                    n_pads    = r_pads - itoa_pkg::CNT_W'(1);
                    if (r_pads == itoa_pkg::CNT_W'(1)) begin
                        n_state = ST_DIG_RD;
                    end
                end
            end
            ST_DIG_RD: begin
                // store read is under way
                n_state = ST_DIG_OUT;
            end
            ST_DIG_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_char  = itoa_pkg::digit_to_char(i_ram_rdata);
                    n_o_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - itoa_pkg::DIGIT_AW'(1);
                        n_state = ST_DIG_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_work   <= n_work;
        r_neg    <= n_neg;
        r_radix  <= n_radix;
        r_pchar  <= n_pchar;
        r_tgt    <= n_tgt;
        r_cnt    <= n_cnt;
        r_pads   <= n_pads;
        r_idx    <= n_idx;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    // Divider and digit store hookup
    assign o_div_req.start    = (r_state == ST_DIV_GO);
    assign o_div_req.dividend = r_work;
    assign o_div_req.divisor  = r_radix;
    assign o_ram_waddr        = r_cnt[itoa_pkg::DIGIT_AW-1:0];
    assign o_ram_wdata        = i_div_rsp.remainder;
    assign o_ram_raddr        = r_idx;

    assign o_sts.busy     = (r_state != ST_IDLE);
    assign o_sts.dividing = (r_state == ST_DIV_WAIT);

    assign o_valid     = r_o_valid;
    assign o_text_char = r_o_char;
    assign o_last      = r_o_last;

endmodule

>>> src/integer_to_ascii_radix.sv
// Integer to ASCII text converter, top level.
// Instantiates itoa_front, itoa_back, itoa_div and itoa_ram; uses itoa_pkg.
//
// Input channel (i_valid / o_stall): one 32-bit value and a signed flag per
// item. Output channel (o_valid / i_stall): one ASCII character per item, most
// significant first, o_last high on the final character of each number.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 radix,
// 1 pad character, 2 pad count); write only while the block is idle.
// Digits come from a bit-serial divider: each digit takes a start, 32
// shift/subtract steps and a hand-back. Characters then leave at one per
// cycle for sign and padding while the receiver does not stall; each digit
// character first waits for a read of the digit store.
// A two-entry queue sits between the front and the back end, so up to two
// further numbers are accepted while one is being converted.
// Reset (synchronous, active low) empties the queue, idles the sequencer,
// drops o_valid and restores radix 10, pad character '0', pad count 0.
// When the receiver stalls, the current character is held and conversion of
// the number pauses at the next character; the divider is never interrupted.
module integer_to_ascii_radix (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [itoa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [itoa_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    input  logic [itoa_pkg::VALUE_W-1:0]       i_value,
    input  logic                               i_is_signed,
    output logic                               o_stall,
    output logic                               o_valid,
    output logic [itoa_pkg::CHAR_W-1:0]        o_text_char,
    output logic                               o_last,
    input  logic                               i_stall
);

    logic                            job_valid;
    itoa_pkg::t_job                  job;
    logic                            job_take;
    itoa_pkg::t_div_req              div_req;
    itoa_pkg::t_div_rsp              div_rsp;
    logic                            ram_we;
    logic [itoa_pkg::DIGIT_AW-1:0]   ram_waddr;
    logic [itoa_pkg::DIGIT_W-1:0]    ram_wdata;
    logic [itoa_pkg::DIGIT_AW-1:0]   ram_raddr;
    logic [itoa_pkg::DIGIT_W-1:0]    ram_rdata;
    itoa_pkg::t_back_sts             back_sts;

    // Accept, classify, queue
    itoa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .i_is_signed (i_is_signed),
        .o_stall     (o_stall),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_take  (job_take)
    );

    // Divider
    itoa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Digit store
    itoa_ram #(
        .WIDTH (itoa_pkg::DIGIT_W),
        .DEPTH (itoa_pkg::MAX_DIGITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Conversion and emission
    itoa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_sts       (back_sts),
        .o_valid     (o_valid),
        .o_text_char (o_text_char),
        .o_last      (o_last),
        .i_stall     (i_stall)
    );

    // A divider result only arrives while the sequencer waits for it
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> back_sts.dividing)
        else $error("divider result outside a divide step");

    // Jobs are only taken from a non-empty queue by an idle back end
    a_take_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_take |-> (job_valid && !back_sts.busy))
        else $error("job taken from empty queue or by busy back end");

    // An accepted item is waiting in the queue on the next cycle
    a_accept_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> job_valid)
        else $error("accepted item missing from queue");

    // The final character of a number is always a digit
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |->
            ((o_text_char >= itoa_pkg::CH_ZERO && o_text_char <= itoa_pkg::CH_NINE)
             || (o_text_char >= itoa_pkg::CH_LOWER_A
                 && o_text_char <= itoa_pkg::CH_LOWER_Z)))
        else $error("last character is not a digit");

endmodule
